// ----- rtl/core/rcpw_pkg.sv -----
// Package with the types and constants shared by the RC pulse width capture block.
package rcpw_pkg;

   localparam int STAMP_W = 16;
   localparam int WIDTH_W = 15;
   localparam int COUNT_W = 16;
   localparam int CSR_DATA_W = 16;

   localparam logic [WIDTH_W-1:0] MIN_WIDTH_RESET = 15'd800;
   localparam logic [WIDTH_W-1:0] MAX_WIDTH_RESET = 15'd2200;
   localparam logic [STAMP_W-1:0] PERIOD_RESET = 16'd40000;
   localparam logic [WIDTH_W-1:0] CENTRE_RESET = 15'd1500;
   localparam logic [COUNT_W-1:0] FRAME_CAP = 16'd60000;
   localparam logic [WIDTH_W-1:0] WIDTH_MAX = 15'h7FFF;

   typedef enum logic [1:0] {
      OP_EDGE   = 2'd0,
      OP_WRAP   = 2'd1,
      OP_CENTRE = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      REG_MIN_WIDTH    = 2'd0,
      REG_MAX_WIDTH    = 2'd1,
      REG_TIMER_PERIOD = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] width;
      logic               too_short;
      logic               too_long;
      logic               in_range;
   } width_check_type;

endpackage

// ----- rtl/core/rcpw_if.sv -----
// Interfaces for the event, result and register write channels.
interface rcpw_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    opcode;
   logic [1:0]                    channel;
   logic                          level;
   logic [rcpw_pkg::STAMP_W-1:0]  timestamp;
   logic                          all_channels;

   modport source (output valid, opcode, channel, level, timestamp, all_channels,
                   input ready);
   modport sink (input valid, opcode, channel, level, timestamp, all_channels,
                 output ready);
endinterface

interface rcpw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    out_channel;
   logic [rcpw_pkg::WIDTH_W-1:0]  width_us;
   logic signed [15:0]            centre_offset;
   logic                          pulse_valid;
   logic                          too_short;
   logic                          too_long;
   logic                          pulse_lost;
   logic                          wrapped;
   logic [rcpw_pkg::COUNT_W-1:0]  valid_frames;

   modport source (output valid, out_channel, width_us, centre_offset, pulse_valid,
                   too_short, too_long, pulse_lost, wrapped, valid_frames,
                   input ready);
   modport sink (input valid, out_channel, width_us, centre_offset, pulse_valid,
                 too_short, too_long, pulse_lost, wrapped, valid_frames,
                 output ready);
endinterface

interface rcpw_csr_if;
   logic                             valid;
   logic                             ready;
   logic [1:0]                       reg_index;
   logic [rcpw_pkg::CSR_DATA_W-1:0]  wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/core/rcpw_width_check.sv -----
// Pulse width arithmetic: tick difference with wrap correction, scaling and range check.
module rcpw_width_check #(
   parameter int STAMP_BITS = 16
) (
   input  logic [STAMP_BITS-1:0]         fall_time,
   input  logic [STAMP_BITS-1:0]         rise_time,
   input  logic                          wrap_seen,
   input  logic [rcpw_pkg::STAMP_W-1:0]  timer_period,
   input  logic [rcpw_pkg::WIDTH_W-1:0]  min_width,
   input  logic [rcpw_pkg::WIDTH_W-1:0]  max_width,
   output rcpw_pkg::width_check_type     result
);
   import rcpw_pkg::*;

   logic [STAMP_BITS+STAMP_W-1:0] period_wide;
   logic [STAMP_BITS-1:0]         period_ext;
   logic [STAMP_BITS-1:0]         ticks;
   logic [STAMP_BITS+15:0]        half_wide;
   logic [WIDTH_W-1:0]            width;

   always_comb begin
      period_wide = {{STAMP_BITS{1'b0}}, timer_period};
      period_ext = period_wide[STAMP_BITS-1:0];
      ticks = fall_time + (wrap_seen ? period_ext : '0) - rise_time;
      half_wide = {16'b0, ticks} >> 1;
      if (half_wide > (STAMP_BITS+16)'(WIDTH_MAX)) begin
         width = WIDTH_MAX;
      end else begin
         width = half_wide[WIDTH_W-1:0];
      end
      result.width = width;
      result.too_short = width < min_width;
      result.too_long = !result.too_short && (width > max_width);
      result.in_range = !result.too_short && !result.too_long;
   end

endmodule

// ----- rtl/core/rc_pulse_width_capture_unit.sv -----
// Top level of the RC receiver pulse width capture block.
//
//   channel   direction  word
//   req_bus   in         one event: pin edge, timer wrap tick or centre capture
//   rsp_bus   out        one measured pulse, sent on a falling edge ending a pulse
//   csr_bus   in         register write: min width, max width, timer period
//
// Each event is resolved while it sits in the input register and its result is registered
// as the event leaves it, so one event is taken per cycle while the output is not stalled.
// Per-channel state is read and written in that one stage, so events never overlap.
// A held result stalls the input register only when it is not taken that cycle.
// Synchronous reset restores the register defaults and all channel state at once.
module rc_pulse_width_capture_unit #(
   parameter int CHANNELS = 4,
   parameter int STAMP_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   rcpw_req_if.sink     req_bus,
   rcpw_rsp_if.source   rsp_bus,
   rcpw_csr_if.sink     csr_bus
);
   import rcpw_pkg::*;

   logic [WIDTH_W-1:0]    min_width_ff;
   logic [WIDTH_W-1:0]    max_width_ff;
   logic [STAMP_W-1:0]    period_ff;

   logic                  s1_valid_ff;
   logic [1:0]            s1_op_ff;
   logic [1:0]            s1_ch_ff;
   logic                  s1_level_ff;
   logic [STAMP_W-1:0]    s1_ts_ff;
   logic                  s1_all_ff;

   logic [STAMP_BITS-1:0] rise_time_ff [CHANNELS];
   logic [CHANNELS-1:0]   pending_ff;
   logic [CHANNELS-1:0]   wrap_ff;
   logic [CHANNELS-1:0]   lost_ff;
   logic [WIDTH_W-1:0]    last_width_ff [CHANNELS];
   logic [WIDTH_W-1:0]    centre_ff [CHANNELS];
   logic [COUNT_W-1:0]    frame_count_ff;
   logic [COUNT_W-1:0]    frame_count_in;

   logic                  rsp_valid_ff;
   logic [1:0]            rsp_channel_ff;
   width_check_type       rsp_check_ff;
   logic [15:0]           rsp_offset_ff;
   logic                  rsp_lost_ff;
   logic                  rsp_wrapped_ff;

   logic [CHANNELS-1:0]   hit;
   logic [STAMP_BITS-1:0] sel_rise;
   logic                  sel_pending;
   logic                  sel_wrap;
   logic                  sel_lost;
   logic [WIDTH_W-1:0]    sel_last;
   logic [WIDTH_W-1:0]    sel_centre;
   logic [STAMP_BITS+STAMP_W-1:0] ts_wide;
   logic [STAMP_BITS-1:0] ts_ext;
   logic                  s1_advance;
   logic                  fall_evt;
   logic [WIDTH_W-1:0]    new_last;
   logic [15:0]           offset_in;
   width_check_type       check;

   assign csr_bus.ready = 1'b1;
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || s1_advance;

   always_comb begin
      sel_rise = '0;
      sel_pending = 1'b0;
      sel_wrap = 1'b0;
      sel_lost = 1'b0;
      sel_last = '0;
      sel_centre = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         hit[i] = (5'(i) == {3'b000, s1_ch_ff});
         if (hit[i]) begin
            sel_rise = rise_time_ff[i];
            sel_pending = pending_ff[i];
            sel_wrap = wrap_ff[i];
            sel_lost = lost_ff[i];
            sel_last = last_width_ff[i];
            sel_centre = centre_ff[i];
         end
      end
      ts_wide = {{STAMP_BITS{1'b0}}, s1_ts_ff};
      ts_ext = ts_wide[STAMP_BITS-1:0];
      fall_evt = (s1_op_ff == OP_EDGE) && (|hit) && !s1_level_ff && sel_pending;
      new_last = check.in_range ? check.width : sel_last;
      offset_in = {1'b0, new_last} - {1'b0, sel_centre};
      if (!check.in_range) begin
         frame_count_in = '0;
      end else if (frame_count_ff < FRAME_CAP) begin
         frame_count_in = frame_count_ff + 16'd1;
      end else begin
         frame_count_in = frame_count_ff;
      end
   end

   rcpw_width_check #(
      .STAMP_BITS (STAMP_BITS)
   ) u_width_check (
      .fall_time    (ts_ext),
      .rise_time    (sel_rise),
      .wrap_seen    (sel_wrap),
      .timer_period (period_ff),
      .min_width    (min_width_ff),
      .max_width    (max_width_ff),
      .result       (check)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_width_ff <= MIN_WIDTH_RESET;
         max_width_ff <= MAX_WIDTH_RESET;
         period_ff <= PERIOD_RESET;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.reg_index)
            REG_MIN_WIDTH:    min_width_ff <= csr_bus.wdata[WIDTH_W-1:0];
            REG_MAX_WIDTH:    max_width_ff <= csr_bus.wdata[WIDTH_W-1:0];
            REG_TIMER_PERIOD: period_ff <= csr_bus.wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         s1_valid_ff <= req_bus.valid;
      end
      if (req_bus.ready) begin
         s1_op_ff <= req_bus.opcode;
         s1_ch_ff <= req_bus.channel;
         s1_level_ff <= req_bus.level;
         s1_ts_ff <= req_bus.timestamp;
         s1_all_ff <= req_bus.all_channels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
         wrap_ff <= '0;
         lost_ff <= '0;
         frame_count_ff <= '0;
         for (int i = 0; i < CHANNELS; i++) begin
            rise_time_ff[i] <= '0;
            last_width_ff[i] <= '0;
            centre_ff[i] <= CENTRE_RESET;
         end
      end else if (s1_advance) begin
         unique case (s1_op_ff)
            OP_WRAP: begin
               wrap_ff <= '1;
            end
            OP_CENTRE: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (s1_all_ff || hit[i]) begin
                     centre_ff[i] <= last_width_ff[i];
                  end
               end
            end
            OP_EDGE: begin
               for (int i = 0; i < CHANNELS; i++) begin
                  if (hit[i] && s1_level_ff) begin
                     lost_ff[i] <= lost_ff[i] | pending_ff[i];
                     rise_time_ff[i] <= ts_ext;
                     pending_ff[i] <= 1'b1;
                     wrap_ff[i] <= 1'b0;
                  end else if (hit[i] && pending_ff[i]) begin
                     pending_ff[i] <= 1'b0;
                     lost_ff[i] <= 1'b0;
                     wrap_ff[i] <= 1'b0;
                     last_width_ff[i] <= new_last;
                  end
               end
               if (fall_evt) begin
                  frame_count_ff <= frame_count_in;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance && fall_evt) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_advance && fall_evt) begin
         rsp_channel_ff <= s1_ch_ff;
         rsp_check_ff <= check;
         rsp_offset_ff <= offset_in;
         rsp_lost_ff <= sel_lost;
         rsp_wrapped_ff <= sel_wrap;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.out_channel = rsp_channel_ff;
   assign rsp_bus.width_us = rsp_check_ff.width;
   assign rsp_bus.centre_offset = rsp_offset_ff;
   assign rsp_bus.pulse_valid = rsp_check_ff.in_range;
   assign rsp_bus.too_short = rsp_check_ff.too_short;
   assign rsp_bus.too_long = rsp_check_ff.too_long;
   assign rsp_bus.pulse_lost = rsp_lost_ff;
   assign rsp_bus.wrapped = rsp_wrapped_ff;
   assign rsp_bus.valid_frames = frame_count_ff;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the RC pulse width capture unit with a built-in predictor.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import rcpw_pkg::*;

   localparam logic [1:0] OP_SPARE = 2'd3;
   localparam logic [1:0] REG_SPARE = 2'd3;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_LIMIT = 2000;
   localparam int BURST_PULSES = 40;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [1:0]         channel;
      logic               level;
      logic [STAMP_W-1:0] timestamp;
      logic               all_channels;
   } event_word_type;

   typedef struct packed {
      logic [1:0]         out_channel;
      logic [WIDTH_W-1:0] width_us;
      logic signed [15:0] centre_offset;
      logic               pulse_valid;
      logic               too_short;
      logic               too_long;
      logic               pulse_lost;
      logic               wrapped;
      logic [COUNT_W-1:0] valid_frames;
   } pulse_word_type;

   class pulse_scoreboard;
      logic [WIDTH_W-1:0] min_width;
      logic [WIDTH_W-1:0] max_width;
      logic [STAMP_W-1:0] period;
      logic [STAMP_W-1:0] rise_stamp [4];
      bit                 rise_open [4];
      bit                 wrap_mark [4];
      bit                 lost_mark [4];
      logic [WIDTH_W-1:0] last_width [4];
      logic [WIDTH_W-1:0] centre_width [4];
      logic [COUNT_W-1:0] frame_count;
      pulse_word_type     pending_pulses [$];
      int                 mismatches;
      int                 checked;

      function new();
         min_width = MIN_WIDTH_RESET;
         max_width = MAX_WIDTH_RESET;
         period = PERIOD_RESET;
         foreach (rise_stamp[i]) begin
            rise_stamp[i] = '0;
            rise_open[i] = 0;
            wrap_mark[i] = 0;
            lost_mark[i] = 0;
            last_width[i] = '0;
            centre_width[i] = CENTRE_RESET;
         end
         frame_count = '0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void set_register(logic [1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            REG_MIN_WIDTH: min_width = data[WIDTH_W-1:0];
            REG_MAX_WIDTH: max_width = data[WIDTH_W-1:0];
            REG_TIMER_PERIOD: period = data[STAMP_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_event(event_word_type ev);
         logic [STAMP_W-1:0] ticks;
         logic [WIDTH_W-1:0] w;
         pulse_word_type p;
         int c;
         c = int'(ev.channel);
         case (ev.opcode)
            OP_WRAP: foreach (wrap_mark[i]) wrap_mark[i] = 1;
            OP_CENTRE: begin
               if (ev.all_channels) begin
                  foreach (centre_width[i]) centre_width[i] = last_width[i];
               end else begin
                  centre_width[c] = last_width[c];
               end
            end
            OP_EDGE: begin
               if (ev.level) begin
                  if (rise_open[c]) lost_mark[c] = 1;
                  rise_stamp[c] = ev.timestamp;
                  rise_open[c] = 1;
                  wrap_mark[c] = 0;
               end else if (rise_open[c]) begin
                  ticks = ev.timestamp + (wrap_mark[c] ? period : 16'd0) - rise_stamp[c];
                  w = ticks[STAMP_W-1:1];
                  p.out_channel = ev.channel;
                  p.width_us = w;
                  p.too_short = w < min_width;
                  p.too_long = !p.too_short && w > max_width;
                  p.pulse_valid = !p.too_short && !p.too_long;
                  p.pulse_lost = lost_mark[c];
                  p.wrapped = wrap_mark[c];
                  if (p.pulse_valid) begin
                     if (frame_count < FRAME_CAP) frame_count = frame_count + 1'b1;
                     last_width[c] = w;
                  end else begin
                     frame_count = '0;
                  end
                  rise_open[c] = 0;
                  lost_mark[c] = 0;
                  wrap_mark[c] = 0;
                  p.centre_offset = {1'b0, last_width[c]} - {1'b0, centre_width[c]};
                  p.valid_frames = frame_count;
                  pending_pulses.push_back(p);
               end
            end
            default: ;
         endcase
      endfunction

      function string describe(pulse_word_type p);
         return {$sformatf("ch=%0d width=%0d offset=%0d valid=%b ",
                           p.out_channel, p.width_us, p.centre_offset, p.pulse_valid),
                 $sformatf("short=%b long=%b lost=%b wrap=%b frames=%0d",
                           p.too_short, p.too_long, p.pulse_lost, p.wrapped,
                           p.valid_frames)};
      endfunction

      function void check_result(pulse_word_type got);
         pulse_word_type want;
         checked++;
         if (pending_pulses.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected pulse result: %s", describe(got));
         end else begin
            want = pending_pulses.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Pulse result mismatch, expected %s", describe(want));
                  $display("                       actual   %s", describe(got));
               end
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   rcpw_req_if req_bus();
   rcpw_rsp_if rsp_bus();
   rcpw_csr_if csr_bus();

   rc_pulse_width_capture_unit dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   pulse_scoreboard board = new();

   bit req_idle;
   bit rsp_idle;
   int stall_left;
   int quiet_cycles;
   int events_sent;
   int registers_written;
   int settings_used;
   bit [STAMP_W-1:0] stim_rise [4];
   bit stim_open [4];
   bit stim_wrapped [4];

   initial clock = 1'b0;
   always #10 clock = ~clock;

   function automatic int pick_gap(bit enabled);
      int r;
      r = $urandom_range(0, 99);
      if (!enabled || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   task automatic issue(event_word_type ev);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.opcode <= ev.opcode;
      req_bus.channel <= ev.channel;
      req_bus.level <= ev.level;
      req_bus.timestamp <= ev.timestamp;
      req_bus.all_channels <= ev.all_channels;
      do @(posedge clock); while (!req_bus.ready);
      board.note_event(ev);
      events_sent++;
      gap = pick_gap(req_idle);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue_fields(logic [1:0] op, logic [1:0] ch, logic lvl,
                               logic [STAMP_W-1:0] ts, logic all);
      event_word_type ev;
      ev.opcode = op;
      ev.channel = ch;
      ev.level = lvl;
      ev.timestamp = ts;
      ev.all_channels = all;
      issue(ev);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.pending_pulses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [1:0] index, logic [CSR_DATA_W-1:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.reg_index <= index;
      csr_bus.wdata <= data;
      do @(posedge clock); while (!csr_bus.ready);
      board.set_register(index, data);
      registers_written++;
   endtask

   task automatic configure(logic [CSR_DATA_W-1:0] min_w, logic [CSR_DATA_W-1:0] max_w,
                            logic [CSR_DATA_W-1:0] ticks_per_wrap);
      write_register(REG_MIN_WIDTH, min_w);
      write_register(REG_MAX_WIDTH, max_w);
      write_register(REG_TIMER_PERIOD, ticks_per_wrap);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   function automatic event_word_type next_event();
      event_word_type ev;
      int r;
      int c;
      int target;
      logic [STAMP_W-1:0] ticks;
      r = $urandom_range(0, 99);
      c = $urandom_range(0, 3);
      ev.opcode = OP_EDGE;
      ev.channel = 2'(c);
      ev.level = 1'b0;
      ev.timestamp = 16'($urandom);
      ev.all_channels = 1'($urandom_range(0, 1));
      if (r < 8) begin
         ev.opcode = 2'($urandom_range(0, 3));
         ev.level = 1'($urandom_range(0, 1));
      end else if (r < 14) begin
         ev.opcode = OP_WRAP;
         foreach (stim_wrapped[i]) stim_wrapped[i] = 1;
      end else if (r < 18) begin
         ev.opcode = OP_CENTRE;
      end else if (!stim_open[c] || r < 22) begin
         ev.level = 1'b1;
         stim_open[c] = 1;
         stim_rise[c] = ev.timestamp;
         stim_wrapped[c] = 0;
      end else begin
         if (board.min_width <= board.max_width && $urandom_range(0, 9) < 7)
            target = $urandom_range(int'(board.min_width), int'(board.max_width));
         else
            target = $urandom_range(0, 32767);
         ticks = 16'(target * 2 + $urandom_range(0, 1));
         ev.timestamp = stim_rise[c] + ticks - (stim_wrapped[c] ? board.period : 16'd0);
         stim_open[c] = 0;
      end
      return ev;
   endfunction

   task automatic run_random(int count);
      repeat (count) issue(next_event());
   endtask

   task automatic run_pulse_burst();
      logic [STAMP_W-1:0] rise;
      logic [1:0] ch;
      repeat (BURST_PULSES) begin
         ch = 2'($urandom_range(0, 3));
         rise = 16'($urandom);
         issue_fields(OP_EDGE, ch, 1'b1, rise, 1'b0);
         issue_fields(OP_EDGE, ch, 1'b0, rise + 16'($urandom_range(0, 65535)), 1'b0);
      end
   endtask

   initial begin
      pulse_word_type got;
      rsp_bus.ready = 1'b0;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.out_channel = rsp_bus.out_channel;
            got.width_us = rsp_bus.width_us;
            got.centre_offset = rsp_bus.centre_offset;
            got.pulse_valid = rsp_bus.pulse_valid;
            got.too_short = rsp_bus.too_short;
            got.too_long = rsp_bus.too_long;
            got.pulse_lost = rsp_bus.pulse_lost;
            got.wrapped = rsp_bus.wrapped;
            got.valid_frames = rsp_bus.valid_frames;
            board.check_result(got);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            stall_left = pick_gap(rsp_idle);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("Watchdog expired after %0d quiet cycles", QUIET_LIMIT);
            $display("rc_pulse_width_capture_unit verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.opcode = OP_EDGE;
      req_bus.channel = '0;
      req_bus.level = 1'b0;
      req_bus.timestamp = '0;
      req_bus.all_channels = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.reg_index = REG_MIN_WIDTH;
      csr_bus.wdata = '0;
      quiet_cycles = 0;
      events_sent = 0;
      registers_written = 0;
      settings_used = 1;
      foreach (stim_open[i]) begin
         stim_open[i] = 0;
         stim_rise[i] = '0;
         stim_wrapped[i] = 0;
      end
      req_idle = 1;
      rsp_idle = 1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue_fields(OP_EDGE, 2'd0, 1'b0, 16'd500, 1'b0);
      issue_fields(OP_EDGE, 2'd0, 1'b1, 16'd100, 1'b0);
      issue_fields(OP_EDGE, 2'd0, 1'b0, 16'd3100, 1'b0);
      issue_fields(OP_SPARE, 2'd2, 1'b1, 16'hFFFF, 1'b1);
      issue_fields(OP_CENTRE, 2'd0, 1'b0, 16'd0, 1'b0);
      issue_fields(OP_EDGE, 2'd1, 1'b1, 16'hFFFF, 1'b0);
      issue_fields(OP_WRAP, 2'd3, 1'b1, 16'd0, 1'b1);
      issue_fields(OP_EDGE, 2'd1, 1'b0, 16'd0, 1'b0);
      issue_fields(OP_EDGE, 2'd2, 1'b1, 16'd0, 1'b0);
      issue_fields(OP_EDGE, 2'd2, 1'b1, 16'd1000, 1'b0);
      issue_fields(OP_EDGE, 2'd2, 1'b0, 16'd2600, 1'b0);
      issue_fields(OP_EDGE, 2'd3, 1'b1, 16'd0, 1'b0);
      issue_fields(OP_EDGE, 2'd3, 1'b0, 16'd4400, 1'b0);
      issue_fields(OP_EDGE, 2'd3, 1'b1, 16'd0, 1'b0);
      issue_fields(OP_EDGE, 2'd3, 1'b0, 16'd4402, 1'b0);
      issue_fields(OP_EDGE, 2'd0, 1'b1, 16'd0, 1'b0);
      issue_fields(OP_EDGE, 2'd0, 1'b0, 16'd1598, 1'b0);
      issue_fields(OP_CENTRE, 2'd1, 1'b0, 16'd0, 1'b1);
      issue_fields(OP_EDGE, 2'd1, 1'b1, 16'd0, 1'b0);
      issue_fields(OP_EDGE, 2'd1, 1'b0, 16'hFFFF, 1'b0);
      issue_fields(OP_EDGE, 2'd1, 1'b1, 16'hFFFF, 1'b0);
      issue_fields(OP_EDGE, 2'd1, 1'b0, 16'hFFFF, 1'b0);
      settle();

      write_register(REG_SPARE, 16'hFFFF);
      configure(16'd0, 16'h7FFF, 16'hFFFF);
      run_random(300);
      settle();

      req_idle = 1;
      rsp_idle = 0;
      configure(16'h7FFF, 16'd0, 16'd1);
      run_random(250);
      settle();

      req_idle = 0;
      rsp_idle = 1;
      configure(16'h8000 | 16'd1000, 16'h8000 | 16'd2000, 16'd40000);
      run_random(300);
      settle();

      req_idle = 0;
      rsp_idle = 0;
      configure(16'd0, 16'h7FFF, PERIOD_RESET);
      run_pulse_burst();
      settle();

      repeat (3) begin
         req_idle = 1'($urandom_range(0, 1));
         rsp_idle = 1'($urandom_range(0, 1));
         configure({1'($urandom_range(0, 1)), 15'($urandom_range(0, 1500))},
                   {1'($urandom_range(0, 1)), 15'($urandom_range(1500, 32767))},
                   16'($urandom_range(1, 65535)));
         run_random(300);
         settle();
      end

      $display("Sent %0d event words and %0d register writes across %0d settings.",
               events_sent, registers_written, settings_used);
      $display("Checked %0d pulse results, including a back-to-back pulse burst.",
               board.checked);
      if (board.mismatches == 0 && board.pending_pulses.size() == 0) begin
         $display("rc_pulse_width_capture_unit verification clean");
      end else begin
         $display("Mismatches: %0d", board.mismatches);
         $display("rc_pulse_width_capture_unit verification failed");
      end
      $finish;
   end

endmodule
